### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are switched off while rst_n is low.
`define STG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define STG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/stg_pkg.sv
`default_nettype none

package stg_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_BURST    = 64;
  localparam int ATAN_SLOTS   = 24;

  localparam int FREQ_W   = 17;
  localparam int RATE_W   = 18;
  localparam int PHASE_W  = 18;
  localparam int COUNT_W  = 7;
  localparam int TURN_W   = 32;
  localparam int ANGLE_W  = 30;
  localparam int HP_W     = 31;
  localparam int Z_W      = 33;
  localparam int XY_W     = SAMPLE_BITS + 32;
  localparam int RND_W    = XY_W - ANGLE_W;

  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_CYCLES     = TURN_W / DIV_RADIX_BITS;

  localparam int CNT_W      = $clog2((CORDIC_STEPS > DIV_CYCLES) ? CORDIC_STEPS : DIV_CYCLES);
  localparam int BURST_W    = $clog2(MAX_BURST + 1);
  localparam int ATAN_IDX_W = $clog2(ATAN_SLOTS);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQUENCY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = CFG_IDX_W'(1);

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(440);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

  // Quarter turn in radians, Q30.
  localparam logic [HP_W-1:0] HALF_PI_Q30 = HP_W'(1686629713);

  // Reciprocal of the gain of sixteen rotation steps, Q30; it belongs to CORDIC_STEPS.
  localparam logic [ANGLE_W-1:0] INV_GAIN_Q30 = ANGLE_W'(652032875);

  localparam logic signed [XY_W-1:0] X_START =
    $signed({{(XY_W - ANGLE_W){1'b0}}, INV_GAIN_Q30}) <<< (SAMPLE_BITS - 2);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_AMP =
    SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);

  typedef struct packed {
    logic             prep;
    logic             div_step;
    logic             mul;
    logic             rot;
    logic             emit;
    logic             last;
    logic [CNT_W-1:0] step;
  } stg_cmd_t;

  typedef struct packed {
    logic bad;
    logic out_free;
  } stg_status_t;

  function automatic logic [ANGLE_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      ATAN_IDX_W'(0):  a = ANGLE_W'(843314857);
      ATAN_IDX_W'(1):  a = ANGLE_W'(497837829);
      ATAN_IDX_W'(2):  a = ANGLE_W'(263043837);
      ATAN_IDX_W'(3):  a = ANGLE_W'(133525159);
      ATAN_IDX_W'(4):  a = ANGLE_W'(67021687);
      ATAN_IDX_W'(5):  a = ANGLE_W'(33543516);
      ATAN_IDX_W'(6):  a = ANGLE_W'(16775851);
      ATAN_IDX_W'(7):  a = ANGLE_W'(8388437);
      ATAN_IDX_W'(8):  a = ANGLE_W'(4194283);
      ATAN_IDX_W'(9):  a = ANGLE_W'(2097149);
      ATAN_IDX_W'(10): a = ANGLE_W'(1048576);
      ATAN_IDX_W'(11): a = ANGLE_W'(524288);
      ATAN_IDX_W'(12): a = ANGLE_W'(262144);
      ATAN_IDX_W'(13): a = ANGLE_W'(131072);
      ATAN_IDX_W'(14): a = ANGLE_W'(65536);
      ATAN_IDX_W'(15): a = ANGLE_W'(32768);
      ATAN_IDX_W'(16): a = ANGLE_W'(16384);
      ATAN_IDX_W'(17): a = ANGLE_W'(8192);
      ATAN_IDX_W'(18): a = ANGLE_W'(4096);
      ATAN_IDX_W'(19): a = ANGLE_W'(2048);
      ATAN_IDX_W'(20): a = ANGLE_W'(1024);
      ATAN_IDX_W'(21): a = ANGLE_W'(512);
      ATAN_IDX_W'(22): a = ANGLE_W'(256);
      ATAN_IDX_W'(23): a = ANGLE_W'(128);
      default:         a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### sv/stg_div.sv
`default_nettype none

module stg_div
  import stg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              step,
  input  wire logic [PHASE_W-1:0] phase,
  input  wire logic [RATE_W-1:0] rate,
  output logic      [TURN_W-1:0] quotient
);

  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [TURN_W-1:0] quo_r, quo_nxt;

  always_comb begin
    logic [RATE_W:0]   rem_v;
    logic [TURN_W-1:0] quo_v;
    logic              qbit;
    rem_v = {1'b0, rem_r};
    quo_v = quo_r;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      rem_v = {rem_v[RATE_W-1:0], 1'b0};
      qbit  = (rem_v >= {1'b0, rate});
      if (qbit) begin
        rem_v = rem_v - {1'b0, rate};
      end
      quo_v = {quo_v[TURN_W-2:0], qbit};
    end
    rem_nxt = rem_v[RATE_W-1:0];
    quo_nxt = quo_v;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= RATE_W'(phase);
      quo_r <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

`default_nettype wire

### sv/stg_cordic.sv
`default_nettype none

module stg_cordic
  import stg_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          init,
  input  wire logic                          rot,
  input  wire logic [CNT_W-1:0]              step,
  input  wire logic [TURN_W-1:0]             turn,
  output logic signed [SAMPLE_BITS-1:0]      value
);

  typedef enum logic [1:0] {
    QUAD_SIN     = 2'd0,
    QUAD_COS     = 2'd1,
    QUAD_NEG_SIN = 2'd2,
    QUAD_NEG_COS = 2'd3
  } quad_t;

  localparam int PROD_W = ANGLE_W + HP_W;
  localparam logic [PROD_W-1:0]     Z_HALF   = PROD_W'(1) << (ANGLE_W - 1);
  localparam logic signed [XY_W-1:0] RND_HALF = XY_W'(1) << (ANGLE_W - 1);
  localparam logic signed [RND_W:0]  AMP_W    = (RND_W + 1)'(1) << (SAMPLE_BITS - 2);

  logic signed [XY_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  quad_t                  quad_r;

  logic [PROD_W-1:0]      zprod;
  logic [PROD_W-1:0]      zsum;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  da;

  assign zprod = {{HP_W{1'b0}}, turn[ANGLE_W-1:0]} * {{ANGLE_W{1'b0}}, HALF_PI_Q30};
  assign zsum  = zprod + Z_HALF;

  assign dx = y_r >>> step;
  assign dy = x_r >>> step;
  assign da = $signed({{(Z_W - ANGLE_W){1'b0}}, atan_q30(ATAN_IDX_W'(step))});

  always_comb begin
    if (!z_r[Z_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - da;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + da;
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      x_r    <= X_START;
      y_r    <= '0;
      z_r    <= $signed(Z_W'(zsum[PROD_W-1:ANGLE_W]));
      quad_r <= quad_t'(turn[TURN_W-1:ANGLE_W]);
    end else if (rot) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    logic signed [XY_W-1:0]  ys, xs;
    logic signed [RND_W:0]   s, c, v;
    ys = y_r + RND_HALF;
    xs = x_r + RND_HALF;
    s  = $signed({ys[XY_W-1], ys[XY_W-1:ANGLE_W]});
    c  = $signed({xs[XY_W-1], xs[XY_W-1:ANGLE_W]});
    unique case (quad_r)
      QUAD_SIN:     v = s;
      QUAD_COS:     v = c;
      QUAD_NEG_SIN: v = -s;
      QUAD_NEG_COS: v = -c;
      default:      v = '0;
    endcase
    if (v > AMP_W) begin
      v = AMP_W;
    end
    if (v < -AMP_W) begin
      v = -AMP_W;
    end
    value = v[SAMPLE_BITS-1:0];
  end

endmodule

`default_nettype wire

### sv/stg_datapath.sv
`default_nettype none

module stg_datapath
  import stg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire stg_cmd_t                 cmd,
  output stg_status_t                   status,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last,
  output logic                          out_config_error
);

  logic [FREQ_W-1:0]  freq_r;
  logic [RATE_W-1:0]  rate_r;
  logic [PHASE_W-1:0] phase_r;
  logic               out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic               out_last_r;
  logic               out_err_r;

  logic               bad;
  logic [PHASE_W-1:0] phase_use;
  logic [PHASE_W:0]   phase_sum;
  logic [PHASE_W:0]   phase_wrap;
  logic [TURN_W-1:0]  turn;
  logic signed [SAMPLE_BITS-1:0] sine;

  assign bad       = (freq_r == '0) || (freq_r > rate_r[RATE_W-1:1]);
  assign phase_use = (phase_r >= rate_r) ? '0 : phase_r;
  assign phase_sum = {1'b0, phase_r} + (PHASE_W + 1)'(freq_r);
  assign phase_wrap = (phase_sum >= (PHASE_W + 1)'(rate_r)) ?
                      phase_sum - (PHASE_W + 1)'(rate_r) : phase_sum;

  stg_div u_div (
    .clk      (clk),
    .load     (cmd.prep),
    .step     (cmd.div_step),
    .phase    (phase_use),
    .rate     (rate_r),
    .quotient (turn)
  );

  stg_cordic u_cordic (
    .clk   (clk),
    .init  (cmd.mul),
    .rot   (cmd.rot),
    .step  (cmd.step),
    .turn  (turn),
    .value (sine)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= FREQ_RESET;
      rate_r      <= RATE_RESET;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TONE_FREQUENCY: freq_r <= cfg_data[FREQ_W-1:0];
          REG_SAMPLE_RATE:    rate_r <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.prep) begin
        phase_r <= phase_use;
      end else if (cmd.emit && !bad) begin
        phase_r <= phase_wrap[PHASE_W-1:0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= bad ? '0 : sine;
      out_last_r   <= cmd.last;
      out_err_r    <= bad;
    end
  end

  assign status.bad      = bad;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_last         = out_last_r;
  assign out_config_error = out_err_r;

endmodule

`default_nettype wire

### sv/stg_ctrl.sv
`default_nettype none

module stg_ctrl
  import stg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [COUNT_W-1:0] in_sample_count,
  input  wire stg_status_t        status,
  output stg_cmd_t                cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_ROT,
    ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic [BURST_W-1:0] remain_r, remain_nxt;
  logic [BURST_W-1:0] count_sat;

  assign count_sat = (in_sample_count > COUNT_W'(MAX_BURST)) ?
                     BURST_W'(MAX_BURST) : BURST_W'(in_sample_count);

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    remain_nxt   = remain_r;
    cmd          = '0;
    cmd.step     = step_r;
    cmd.last     = (remain_r == BURST_W'(1));
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (count_sat != '0)) begin
          remain_nxt = count_sat;
          state_nxt  = status.bad ? ST_EMIT : ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == CNT_W'(DIV_CYCLES - 1)) begin
          state_nxt = ST_MUL;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (step_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          remain_nxt = remain_r - BURST_W'(1);
          if (remain_r == BURST_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = status.bad ? ST_EMIT : ST_PREP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      remain_r <= remain_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

`default_nettype wire

### sv/sine_tone_generator_unit.sv
// Tone generator: each accepted request asks for a burst of 1 to 64 samples of a
// half-amplitude sine (Q1.15, within +/-16384) at tone_frequency over sample_rate;
// longer counts are cut to 64 and a count of zero yields nothing. For each sample
// the block loads the phase, runs a radix-16 divider that turns phase over rate into
// a fraction of a turn, does a multiply, iterates one shared CORDIC rotation stage,
// then hands the sample to the output register when the output is not stalled.
// With a frequency of zero or above half the rate, samples are zero with config_error
// set at one per cycle while the output is not stalled, and the phase holds. A new
// request is taken only once the previous burst has been fully handed over to the
// output register. Registers may be written at any time the block is idle; the
// phase is kept across writes, but a phase not below a newly written rate restarts
// from zero.
`default_nettype none

`include "assert_macros.svh"

module sine_tone_generator_unit
  import stg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [COUNT_W-1:0]       in_sample_count,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last,
  output logic                          out_config_error,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  stg_cmd_t    cmd;
  stg_status_t status;

  assign cfg_ready = 1'b1;

  stg_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_count (in_sample_count),
    .status          (status),
    .cmd             (cmd)
  );

  stg_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sample       (out_sample),
    .out_last         (out_last),
    .out_config_error (out_config_error)
  );

  `STG_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall && (in_sample_count != '0), in_stall, "non-empty request did not start a burst")
  `STG_ASSERT_IMPLY(a_error_gives_zero, out_valid && out_config_error, out_sample == '0, "sample not zero under a configuration error")
  `STG_ASSERT_IMPLY(a_sample_in_range, out_valid, (out_sample <= SAMPLE_AMP) && (out_sample >= -SAMPLE_AMP), "sample beyond half scale")
  `STG_ASSERT_IMPLY(a_idle_only_last_waits, out_valid && !in_stall, out_last, "idle while a burst is unfinished")

endmodule

`default_nettype wire
